// ===== hw/rtl/dsp_pkg.sv =====
package dsp_pkg;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [23:0] DIST_INF = 24'hFFFFFF;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_CLEAR,
    DP_ADD_RD,
    DP_ADD_WR,
    DP_INIT,
    DP_SCAN,
    DP_SETTLE,
    DP_RELAX,
    DP_WALK_RD,
    DP_WALK_PUSH,
    DP_EMIT,
    DP_FAIL
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   cnt_rst;
    logic   cnt_inc;
  } cmd_t;

  typedef struct packed {
    logic [1:0] item_op;
    logic       item_bad;
    logic       item_rep;
    logic       cnt_last;
    logic       clr_last;
    logic       best_found;
    logic       best_hit;
    logic       walk_done;
    logic       emit_last;
    logic       out_free;
  } sts_t;

endpackage

// ===== hw/rtl/dsp_ram.sv =====
module dsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/dsp_dp.sv =====
module dsp_dp #(
  parameter int NODES = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  dsp_pkg::cmd_t cmd,
  output dsp_pkg::sts_t sts,
  input  logic [1:0]    in_op,
  input  logic [3:0]    in_src_node,
  input  logic [3:0]    in_dst_node,
  input  logic [15:0]   in_length,
  input  logic          in_in_repair,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [3:0]    out_node,
  output logic          out_found,
  output logic          out_last
);
  import dsp_pkg::*;

  localparam int NW  = $clog2(NODES);
  localparam int EW  = $clog2(NODES * NODES);
  localparam int PD  = (NODES < 16) ? NODES : 16;
  localparam int PIW = $clog2(PD);
  localparam int NCW = $clog2(NODES + 1);

  logic [1:0]  op_r;
  logic [3:0]  s_r, d_r;
  logic [15:0] len_r;
  logic        rep_r;
  logic [EW-1:0] cnt_r, cnt_nxt;
  logic [NODES-1:0] settled_r;
  logic [NW-1:0] best_r, idx_d_r, at_r;
  logic [23:0] bd_r;
  logic        found_r, scan_pend_r, relax_pend_r;
  logic [NCW-1:0] n_r;
  logic [3:0]  path_r [PD];
  logic        out_valid_r, out_found_r, out_last_r;
  logic [3:0]  out_node_r;

  logic [NW-1:0] cidx, s_idx, d_idx;
  logic [EW-1:0] add_addr, rel_addr, e_waddr, e_raddr;
  logic          e_we, d_we, relax_wr, add_wr;
  logic [16:0]   e_wdata, e_rdata;
  logic [23:0]   dist_rdata, d_wdata, nd_sat;
  logic [24:0]   nd;
  logic [NW-1:0] d_waddr;
  logic [3:0]    p_wdata, p_rdata;

  assign cidx  = cnt_r[NW-1:0];
  assign s_idx = NW'(s_r);
  assign d_idx = NW'(d_r);
  assign add_addr = EW'(s_idx) * EW'(NODES) + EW'(d_idx);
  assign rel_addr = EW'(best_r) * EW'(NODES) + EW'(cidx);

  assign nd       = {1'b0, bd_r} + {9'd0, e_rdata[15:0]};
  assign nd_sat   = (nd > {1'b0, DIST_INF}) ? DIST_INF : nd[23:0];
  assign relax_wr = relax_pend_r && e_rdata[16] && (nd_sat < dist_rdata);
  assign add_wr   = !e_rdata[16] || (len_r < e_rdata[15:0]);

  always_comb begin
    e_we    = 1'b0;
    e_waddr = cnt_r;
    e_wdata = '0;
    e_raddr = rel_addr;
    case (cmd.op)
      DP_CLEAR: begin
        e_we = 1'b1;
      end
      DP_ADD_RD: begin
        e_raddr = add_addr;
      end
      DP_ADD_WR: begin
        e_we    = add_wr;
        e_waddr = add_addr;
        e_wdata = {1'b1, len_r};
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.op == DP_INIT) begin
      d_we    = 1'b1;
      d_waddr = cidx;
      d_wdata = (cidx == s_idx) ? 24'd0 : DIST_INF;
      p_wdata = 4'd0;
    end else begin
      d_we    = relax_wr;
      d_waddr = idx_d_r;
      d_wdata = nd_sat;
      p_wdata = 4'(best_r);
    end
  end

  dsp_ram #(.WIDTH(17), .DEPTH(NODES * NODES)) u_edge (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rdata)
  );

  dsp_ram #(.WIDTH(24), .DEPTH(NODES)) u_dist (
    .clk, .we(d_we), .waddr(d_waddr), .wdata(d_wdata), .raddr(cidx), .rdata(dist_rdata)
  );

  dsp_ram #(.WIDTH(4), .DEPTH(NODES)) u_pred (
    .clk, .we(d_we), .waddr(d_waddr), .wdata(p_wdata), .raddr(at_r), .rdata(p_rdata)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + EW'(1);
    end
    if (cmd.cnt_rst) begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      settled_r    <= '0;
      scan_pend_r  <= 1'b0;
      relax_pend_r <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      op_r         <= OP_CLEAR;
      n_r          <= '0;
    end else begin
      cnt_r        <= cnt_nxt;
      scan_pend_r  <= (cmd.op == DP_SCAN);
      relax_pend_r <= (cmd.op == DP_RELAX);
      idx_d_r      <= cidx;
      if (cmd.op == DP_LOAD) begin
        op_r  <= in_op;
        s_r   <= in_src_node;
        d_r   <= in_dst_node;
        len_r <= in_length;
        rep_r <= in_in_repair;
      end
      if (cmd.op == DP_INIT) begin
        settled_r <= '0;
      end
      if (cmd.op == DP_SCAN && cnt_r == '0) begin
        bd_r    <= DIST_INF;
        found_r <= 1'b0;
      end
      if (scan_pend_r && !settled_r[idx_d_r] && dist_rdata < bd_r) begin
        bd_r    <= dist_rdata;
        best_r  <= idx_d_r;
        found_r <= 1'b1;
      end
      if (cmd.op == DP_SETTLE) begin
        settled_r[best_r] <= 1'b1;
        at_r              <= d_idx;
        path_r[0]         <= d_r;
        n_r               <= NCW'(1);
      end
      if (cmd.op == DP_WALK_PUSH) begin
        at_r <= NW'(p_rdata);
        if (n_r < NCW'(PD)) begin
          path_r[PIW'(n_r)] <= p_rdata;
        end
        n_r <= n_r + NCW'(1);
      end
      if (cmd.op == DP_EMIT) begin
        out_valid_r <= 1'b1;
        out_node_r  <= path_r[PIW'(n_r - NCW'(1))];
        out_found_r <= 1'b1;
        out_last_r  <= (n_r == NCW'(1));
        n_r         <= n_r - NCW'(1);
      end else if (cmd.op == DP_FAIL) begin
        out_valid_r <= 1'b1;
        out_node_r  <= 4'd0;
        out_found_r <= 1'b0;
        out_last_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.item_op    = op_r;
    sts.item_bad   = (int'(s_r) >= NODES) || (int'(d_r) >= NODES);
    sts.item_rep   = rep_r;
    sts.cnt_last   = (cnt_r == EW'(NODES - 1));
    sts.clr_last   = (cnt_r == EW'(NODES * NODES - 1));
    sts.best_found = found_r;
    sts.best_hit   = (best_r == d_idx);
    sts.walk_done  = (at_r == s_idx) || (n_r == NCW'(NODES));
    sts.emit_last  = (n_r == NCW'(1));
    sts.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_node  = out_node_r;
  assign out_found = out_found_r;
  assign out_last  = out_last_r;

endmodule

// ===== hw/rtl/dsp_ctrl.sv =====
module dsp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output dsp_pkg::cmd_t cmd,
  input  dsp_pkg::sts_t sts
);
  import dsp_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_ADD_RD,
    S_ADD_WR,
    S_INIT,
    S_SCAN,
    S_SCAN_TAIL,
    S_PICK,
    S_RELAX,
    S_RELAX_TAIL,
    S_WALK_CHK,
    S_WALK_PUSH,
    S_EMIT,
    S_FAIL
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd.op      = DP_NOP;
    cmd.cnt_rst = 1'b0;
    cmd.cnt_inc = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.op      = DP_CLEAR;
        cmd.cnt_inc = 1'b1;
        if (sts.clr_last) begin
          cmd.cnt_rst = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op      = DP_LOAD;
          cmd.cnt_rst = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.item_op)
          OP_CLEAR: state_nxt = S_CLEAR;
          OP_ADD:   state_nxt = (sts.item_bad || sts.item_rep) ? S_IDLE : S_ADD_RD;
          OP_QUERY: state_nxt = sts.item_bad ? S_FAIL : S_INIT;
          default:  state_nxt = S_IDLE;
        endcase
      end
      S_ADD_RD: begin
        cmd.op    = DP_ADD_RD;
        state_nxt = S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd.op    = DP_ADD_WR;
        state_nxt = S_IDLE;
      end
      S_INIT: begin
        cmd.op      = DP_INIT;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last) begin
          cmd.cnt_rst = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.op      = DP_SCAN;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last) begin
          cmd.cnt_rst = 1'b1;
          state_nxt   = S_SCAN_TAIL;
        end
      end
      S_SCAN_TAIL: state_nxt = S_PICK;
      S_PICK: begin
        if (!sts.best_found) begin
          state_nxt = S_FAIL;
        end else begin
          cmd.op    = DP_SETTLE;
          state_nxt = sts.best_hit ? S_WALK_CHK : S_RELAX;
        end
      end
      S_RELAX: begin
        cmd.op      = DP_RELAX;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last) begin
          cmd.cnt_rst = 1'b1;
          state_nxt   = S_RELAX_TAIL;
        end
      end
      S_RELAX_TAIL: state_nxt = S_SCAN;
      S_WALK_CHK: begin
        if (sts.walk_done) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.op    = DP_WALK_RD;
          state_nxt = S_WALK_PUSH;
        end
      end
      S_WALK_PUSH: begin
        cmd.op    = DP_WALK_PUSH;
        state_nxt = S_WALK_CHK;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.op = DP_EMIT;
          if (sts.emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FAIL: begin
        if (sts.out_free) begin
          cmd.op    = DP_FAIL;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ===== hw/rtl/dijkstra_shortest_path.sv =====
// Clear word: sweeps the edge store, one entry per cycle.
// Add word: read-modify-write of one edge store entry.
// Query word: initialises the distance table, then per settled station runs a distance scan
//   plus edge row relax (scan only for the end station), then per path station a walk
//   plus emit, each emit waiting while out_stall holds the previous result.
// Reset (rst_n low, synchronous) empties the graph by a sweep of the edge store with in_stall high.
module dijkstra_shortest_path #(
  parameter int NODES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [3:0]  in_src_node,
  input  logic [3:0]  in_dst_node,
  input  logic [15:0] in_length,
  input  logic        in_in_repair,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_node,
  output logic        out_found,
  output logic        out_last
);
  import dsp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dsp_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .cmd, .sts
  );

  dsp_dp #(.NODES(NODES)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_op, .in_src_node, .in_dst_node, .in_length, .in_in_repair,
    .out_valid, .out_stall, .out_node, .out_found, .out_last
  );

endmodule

// ===== hw/rtl/dsp_check.sv =====
module dsp_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_op,
  input logic [3:0]  in_src_node,
  input logic [3:0]  in_dst_node,
  input logic [15:0] in_length,
  input logic        in_in_repair,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_node,
  input logic        out_found,
  input logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_node) && $stable(out_found)
      && $stable(out_last))
    else $error("stalled result changed");

  a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_last && out_node == 4'd0)
    else $error("unreachable result not single");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_stall)
    else $error("reset state wrong");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted back to back");

endmodule

bind dijkstra_shortest_path dsp_check u_check (.*);

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dsp_pkg::*;

  localparam int NODES = 16;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 3000;
  localparam int TAIL_CYCLES = 600;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [3:0]  src;
    logic [3:0]  dst;
    logic [15:0] len;
    logic        rep;
    bit          drain;
  } word_t;

  typedef struct {
    logic [3:0] node;
    logic       found;
    logic       last;
  } hop_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op = OP_CLEAR;
  logic [3:0]  in_src_node = '0;
  logic [3:0]  in_dst_node = '0;
  logic [15:0] in_length = '0;
  logic        in_in_repair = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_node;
  logic        out_found;
  logic        out_last;

  word_t       pending[$];
  hop_t        path_exp[$];
  logic [16:0] pipe_len[NODES][NODES];
  word_t       cur;
  hop_t        got;
  hop_t        want;
  int          n_words;
  int          n_acc;
  int          n_hops;
  int          n_queries;
  int          n_unreach;
  int          errors;
  int          cycles;
  int          hold_at;
  int          hold_left;
  bit          hold_done;

  dijkstra_shortest_path #(.NODES(NODES)) dut (.*);

  always #2 clk = ~clk;

  function automatic int idle_pct(bit rx);
    if (n_acc < n_words / 3) return rx ? 65 : 7;
    if (n_acc < 2 * n_words / 3) return rx ? 7 : 65;
    return 0;
  endfunction

  task automatic find_path(logic [3:0] s, logic [3:0] e);
    logic [23:0] tent_dist[NODES];
    logic [3:0]  pred[NODES];
    bit          done[NODES];
    logic [3:0]  trail[$];
    logic [23:0] bd;
    logic [23:0] nd;
    logic [3:0]  at;
    int          best;
    hop_t        h;
    n_queries++;
    for (int i = 0; i < NODES; i++) begin
      tent_dist[i] = DIST_INF;
      pred[i] = '0;
      done[i] = 1'b0;
    end
    tent_dist[s] = '0;
    forever begin
      best = NODES;
      bd = DIST_INF;
      for (int i = 0; i < NODES; i++)
        if (!done[i] && tent_dist[i] < bd) begin
          bd = tent_dist[i];
          best = i;
        end
      if (best >= NODES) break;
      done[best] = 1'b1;
      if (best == e) break;
      for (int v = 0; v < NODES; v++)
        if (pipe_len[best][v][16]) begin
          nd = bd + pipe_len[best][v][15:0];
          if (nd < tent_dist[v]) begin
            tent_dist[v] = nd;
            pred[v] = best[3:0];
          end
        end
    end
    if (tent_dist[e] == DIST_INF) begin
      n_unreach++;
      h = '{node: 4'd0, found: 1'b0, last: 1'b1};
      path_exp.insert(path_exp.size(), h);
      return;
    end
    at = e;
    trail.push_front(at);
    while (at != s && trail.size() < NODES) begin
      at = pred[at];
      trail.push_front(at);
    end
    foreach (trail[k]) begin
      h = '{node: trail[k], found: 1'b1, last: (k == trail.size() - 1)};
      path_exp.insert(path_exp.size(), h);
    end
  endtask

  task automatic apply_word(word_t w);
    case (w.op)
      OP_CLEAR: begin
        foreach (pipe_len[i, j]) pipe_len[i][j] = '0;
      end
      OP_ADD: begin
        if (!w.rep && (!pipe_len[w.src][w.dst][16] || w.len < pipe_len[w.src][w.dst][15:0]))
          pipe_len[w.src][w.dst] = {1'b1, w.len};
      end
      OP_QUERY: find_path(w.src, w.dst);
      default: ;
    endcase
  endtask

  task automatic push_word(logic [1:0] op, int s, int d, int len, int rep);
    word_t w;
    w = '{op: op, src: 4'(s), dst: 4'(d), len: 16'(len), rep: 1'(rep), drain: 1'b0};
    pending.insert(pending.size(), w);
    if (op != OP_UNUSED) n_words++;
  endtask

  task automatic push_drain();
    word_t w;
    w = '{op: OP_CLEAR, src: '0, dst: '0, len: '0, rep: 1'b0, drain: 1'b1};
    pending.insert(pending.size(), w);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_word(cur);
        n_acc++;
      end
      if (!(in_valid && in_stall)) begin
        if (pending.size() > 0 && pending[0].drain) begin
          if (path_exp.size() == 0) void'(pending.pop_front());
          in_valid <= 1'b0;
        end else if (pending.size() > 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          cur = pending.pop_front();
          in_valid <= 1'b1;
          in_op <= cur.op;
          in_src_node <= cur.src;
          in_dst_node <= cur.dst;
          in_length <= cur.len;
          in_in_repair <= cur.rep;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{node: out_node, found: out_found, last: out_last};
        if (path_exp.size() == 0) begin
          errors++;
          $display("%0t unexpected word: expected none, actual node=%0d found=%0b last=%0b",
                   $time, got.node, got.found, got.last);
        end else begin
          want = path_exp.pop_front();
          n_hops++;
          if (got.node !== want.node) begin
            errors++;
            $display("%0t node: expected %0d, actual %0d", $time, want.node, got.node);
          end
          if (got.found !== want.found) begin
            errors++;
            $display("%0t found: expected %0b, actual %0b", $time, want.found, got.found);
          end
          if (got.last !== want.last) begin
            errors++;
            $display("%0t last: expected %0b, actual %0b", $time, want.last, got.last);
          end
        end
      end
      if (!hold_done && n_acc >= hold_at) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < idle_pct(1'b1));
      end
    end
  end

  initial begin
    int base;
    int span;
    foreach (pipe_len[i, j]) pipe_len[i][j] = '0;

    push_word(OP_CLEAR, 0, 0, 0, 0);
    push_word(OP_ADD, 0, 1, 9, 0);
    push_word(OP_ADD, 0, 1, 3, 0);
    push_word(OP_ADD, 0, 1, 7, 0);
    push_word(OP_ADD, 1, 2, 0, 0);
    push_word(OP_ADD, 0, 2, 16'hFFFF, 0);
    push_word(OP_ADD, 2, 3, 1, 1);
    push_word(OP_ADD, 3, 3, 0, 0);
    push_word(OP_ADD, 15, 0, 16'hFFFF, 0);
    push_word(OP_UNUSED, 15, 15, 16'hFFFF, 1);
    push_word(OP_QUERY, 0, 2, 0, 0);
    push_word(OP_QUERY, 0, 0, 0, 0);
    push_word(OP_QUERY, 2, 0, 0, 0);
    push_word(OP_QUERY, 0, 3, 0, 0);
    push_word(OP_QUERY, 15, 2, 16'hFFFF, 1);
    push_word(OP_QUERY, 15, 15, 0, 0);
    push_drain();
    push_word(OP_CLEAR, 0, 0, 0, 0);
    for (int i = 0; i < NODES - 1; i++) push_word(OP_ADD, i, i + 1, 1, 0);
    push_word(OP_ADD, 0, 15, 16'hFFFF, 0);
    push_word(OP_QUERY, 0, 15, 0, 0);
    push_word(OP_CLEAR, 0, 0, 0, 0);
    push_word(OP_QUERY, 0, 15, 0, 0);
    hold_at = n_words + 8;

    while (n_words < 180) begin
      if ($urandom_range(3) == 0) push_word(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
      base = $urandom_range(15);
      span = $urandom_range(3, 8);
      repeat ($urandom_range(4, 12))
        push_word(OP_ADD, (base + $urandom_range(span)) % NODES,
                  (base + $urandom_range(span)) % NODES,
                  ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)),
                  ($urandom_range(9) == 0));
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(9) == 0)
          push_word(OP_QUERY, $urandom, $urandom, $urandom, $urandom);
        else
          push_word(OP_QUERY, (base + $urandom_range(span)) % NODES,
                    (base + $urandom_range(span)) % NODES, $urandom, $urandom);
      end
      if ($urandom_range(7) == 0) push_word(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
      if ($urandom_range(15) == 0) push_drain();
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (pending.size() > 0 || in_valid) @(posedge clk);
    while (path_exp.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d words, %0d path queries (%0d unreachable), %0d path stations checked",
             n_acc, n_queries, n_unreach, n_hops);
    $display("Stimulus: parallel, zero-length, self-loop, repair and full-chain pipes; %0d errors",
             errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
